[design/brt_pkg.sv]
// ----------------------------------------------------------------------------
// brt_pkg: shared types and constants of the trie route table
// Node layout, command and status codes, address bit helpers.
// ----------------------------------------------------------------------------
package brt_pkg;

    localparam int NODES   = 1024;
    localparam int NODE_W  = $clog2(NODES);
    localparam int CNT_W   = NODE_W + 1;
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int MAX_LEN = 32;

    typedef struct packed {
        logic [NODE_W-1:0] child1;
        logic [NODE_W-1:0] child0;
        logic              is_end;
        logic [ADDR_W-1:0] gw;
        logic [LEN_W-1:0]  gwlen;
    } node_t;

    localparam int NODE_BITS = $bits(node_t);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] recycle_cnt;
        logic [CNT_W-1:0] alloc_next;
    } brt_stat_t;

    // bit of the address examined at a given trie level (level 0 = bit 31)
    function automatic logic addr_bit(input logic [ADDR_W-1:0] addr,
                                      input logic [LEN_W-1:0] depth);
        logic [4:0] pos;
        pos = 5'(MAX_LEN - 1 - int'(depth));
        return addr[pos];
    endfunction

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len == '0) begin
            m = '0;
        end else begin
            m = {ADDR_W{1'b1}} << (6'(MAX_LEN) - len);
        end
        return m;
    endfunction

endpackage

[design/brt_ram.sv]
// ----------------------------------------------------------------------------
// brt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module brt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/brt_engine.sv]
// ----------------------------------------------------------------------------
// brt_engine: trie walk, insert, prune and free-list sequencer
// Walks one level per cycle through the node RAM and edits it in place.
// ----------------------------------------------------------------------------
module brt_engine (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [brt_pkg::ADDR_W-1:0]   s_addr,
    input  logic [brt_pkg::LEN_W-1:0]    s_len,
    input  logic [brt_pkg::ADDR_W-1:0]   s_gw,
    input  logic [brt_pkg::LEN_W-1:0]    s_gwl,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic                         m_found,
    output logic [brt_pkg::ADDR_W-1:0]   m_prefix,
    output logic [brt_pkg::LEN_W-1:0]    m_len,
    output logic [brt_pkg::ADDR_W-1:0]   m_gw,
    output logic [brt_pkg::LEN_W-1:0]    m_gwl,
    // node RAM
    output logic                         node_we,
    output logic [brt_pkg::NODE_W-1:0]   node_waddr,
    output brt_pkg::node_t               node_wdata,
    output logic [brt_pkg::NODE_W-1:0]   node_raddr,
    input  brt_pkg::node_t               node_rdata,
    // recycle stack RAM
    output logic                         stk_we,
    output logic [brt_pkg::NODE_W-1:0]   stk_waddr,
    output logic [brt_pkg::NODE_W-1:0]   stk_wdata,
    output logic [brt_pkg::NODE_W-1:0]   stk_raddr,
    input  logic [brt_pkg::NODE_W-1:0]   stk_rdata,
    output brt_pkg::brt_stat_t           stat
);

    typedef enum logic [11:0] {
        S_INIT  = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_WALK  = 12'b0000_0000_0100,
        S_INS   = 12'b0000_0000_1000,
        S_IPOP  = 12'b0000_0001_0000,
        S_ILINK = 12'b0000_0010_0000,
        S_IFIN  = 12'b0000_0100_0000,
        S_DCUT  = 12'b0000_1000_0000,
        S_FREAD = 12'b0001_0000_0000,
        S_FPUSH = 12'b0010_0000_0000,
        S_DONE  = 12'b0100_0000_0000,
        S_SPARE = 12'b1000_0000_0000
    } state_t;

    localparam logic [brt_pkg::CNT_W-1:0] NODES_C = brt_pkg::CNT_W'(brt_pkg::NODES);

    state_t                       state_reg, state_next;
    logic [1:0]                   cmd_reg, cmd_next;
    logic [brt_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [brt_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [brt_pkg::ADDR_W-1:0]   gw_reg, gw_next;
    logic [brt_pkg::LEN_W-1:0]    gwl_reg, gwl_next;
    logic [brt_pkg::NODE_W-1:0]   cur_reg, cur_next;
    logic [brt_pkg::LEN_W-1:0]    depth_reg, depth_next;
    brt_pkg::node_t               cur_data_reg, cur_data_next;
    logic                         best_hit_reg, best_hit_next;
    logic [brt_pkg::LEN_W-1:0]    best_len_reg, best_len_next;
    logic [brt_pkg::ADDR_W-1:0]   best_gw_reg, best_gw_next;
    logic [brt_pkg::LEN_W-1:0]    best_gwl_reg, best_gwl_next;
    logic [brt_pkg::NODE_W-1:0]   anc_reg, anc_next;
    logic [brt_pkg::LEN_W-1:0]    anc_d_reg, anc_d_next;
    brt_pkg::node_t               anc_data_reg, anc_data_next;
    logic [brt_pkg::CNT_W-1:0]    alloc_reg, alloc_next;
    logic [brt_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [brt_pkg::NODE_W-1:0]   new_idx_reg, new_idx_next;
    logic                         from_stk_reg, from_stk_next;
    logic [brt_pkg::NODE_W-1:0]   free_reg, free_next;
    logic [1:0]                   r_status_reg, r_status_next;
    logic                         r_found_reg, r_found_next;
    logic [brt_pkg::LEN_W-1:0]    r_len_reg, r_len_next;
    logic [brt_pkg::ADDR_W-1:0]   r_gw_reg, r_gw_next;
    logic [brt_pkg::LEN_W-1:0]    r_gwl_reg, r_gwl_next;
    logic                         m_valid_reg, m_valid_next;
    logic [1:0]                   m_status_reg, m_status_next;
    logic                         m_found_reg, m_found_next;
    logic [brt_pkg::ADDR_W-1:0]   m_prefix_reg, m_prefix_next;
    logic [brt_pkg::LEN_W-1:0]    m_len_reg, m_len_next;
    logic [brt_pkg::ADDR_W-1:0]   m_gw_reg, m_gw_next;
    logic [brt_pkg::LEN_W-1:0]    m_gwl_reg, m_gwl_next;

    logic                         bit_cur;
    logic [brt_pkg::NODE_W-1:0]   nd_child, nd_other, idx;
    logic [brt_pkg::LEN_W-1:0]    missing;
    logic [brt_pkg::CNT_W:0]      avail;
    brt_pkg::node_t               w;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_found  = m_found_reg;
    assign m_prefix = m_prefix_reg;
    assign m_len    = m_len_reg;
    assign m_gw     = m_gw_reg;
    assign m_gwl    = m_gwl_reg;
    assign stat     = '{recycle_cnt: cnt_reg, alloc_next: alloc_reg};

    assign bit_cur  = brt_pkg::addr_bit(addr_reg, depth_reg);
    assign nd_child = bit_cur ? node_rdata.child1 : node_rdata.child0;
    assign nd_other = bit_cur ? node_rdata.child0 : node_rdata.child1;
    assign idx      = from_stk_reg ? stk_rdata : new_idx_reg;
    assign missing  = len_reg - depth_reg;
    assign avail    = {1'b0, cnt_reg} + {1'b0, NODES_C - alloc_reg};

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        gw_next       = gw_reg;
        gwl_next      = gwl_reg;
        cur_next      = cur_reg;
        depth_next    = depth_reg;
        cur_data_next = cur_data_reg;
        best_hit_next = best_hit_reg;
        best_len_next = best_len_reg;
        best_gw_next  = best_gw_reg;
        best_gwl_next = best_gwl_reg;
        anc_next      = anc_reg;
        anc_d_next    = anc_d_reg;
        anc_data_next = anc_data_reg;
        alloc_next    = alloc_reg;
        cnt_next      = cnt_reg;
        new_idx_next  = new_idx_reg;
        from_stk_next = from_stk_reg;
        free_next     = free_reg;
        r_status_next = r_status_reg;
        r_found_next  = r_found_reg;
        r_len_next    = r_len_reg;
        r_gw_next     = r_gw_reg;
        r_gwl_next    = r_gwl_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_prefix_next = m_prefix_reg;
        m_len_next    = m_len_reg;
        m_gw_next     = m_gw_reg;
        m_gwl_next    = m_gwl_reg;
        node_we       = 1'b0;
        node_waddr    = cur_reg;
        node_wdata    = '0;
        node_raddr    = cur_reg;
        stk_we        = 1'b0;
        stk_waddr     = cnt_reg[brt_pkg::NODE_W-1:0];
        stk_wdata     = free_reg;
        stk_raddr     = brt_pkg::NODE_W'(cnt_reg - 1'b1);
        w             = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT: begin
                // root starts cleared
                node_we    = 1'b1;
                node_waddr = '0;
                node_wdata = '0;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next      = s_cmd;
                    addr_next     = s_addr;
                    len_next      = (s_len > brt_pkg::LEN_W'(brt_pkg::MAX_LEN)) ?
                                    brt_pkg::LEN_W'(brt_pkg::MAX_LEN) : s_len;
                    gw_next       = s_gw;
                    gwl_next      = s_gwl;
                    cur_next      = '0;
                    depth_next    = '0;
                    best_hit_next = 1'b0;
                    anc_next      = '0;
                    anc_d_next    = '0;
                    node_raddr    = '0;
                    r_status_next = brt_pkg::ST_OK;
                    r_found_next  = 1'b0;
                    r_len_next    = '0;
                    r_gw_next     = '0;
                    r_gwl_next    = '0;
                    state_next    = S_WALK;
                end
            end
            S_WALK: begin
                if (node_rdata.is_end) begin
                    best_hit_next = 1'b1;
                    best_len_next = depth_reg;
                    best_gw_next  = node_rdata.gw;
                    best_gwl_next = node_rdata.gwlen;
                end
                if (depth_reg < len_reg && nd_child != '0) begin
                    // deepest node that survives pruning of the path below it
                    if (depth_reg == '0 || node_rdata.is_end || nd_other != '0) begin
                        anc_next      = cur_reg;
                        anc_d_next    = depth_reg;
                        anc_data_next = node_rdata;
                    end
                    cur_next   = nd_child;
                    depth_next = depth_reg + 1'b1;
                    node_raddr = nd_child;
                end else begin
                    cur_data_next = node_rdata;
                    state_next    = S_DONE;
                    case (cmd_reg)
                        brt_pkg::CMD_INSERT: begin
                            state_next = S_INS;
                        end
                        brt_pkg::CMD_DELETE: begin
                            if (depth_reg < len_reg || !node_rdata.is_end) begin
                                r_status_next = brt_pkg::ST_NOT_FOUND;
                            end else if (depth_reg == '0 || node_rdata.child0 != '0 ||
                                         node_rdata.child1 != '0) begin
                                w          = node_rdata;
                                w.is_end   = 1'b0;
                                node_we    = 1'b1;
                                node_wdata = w;
                            end else begin
                                state_next = S_DCUT;
                            end
                        end
                        brt_pkg::CMD_LOOKUP: begin
                            if (node_rdata.is_end) begin
                                r_found_next = 1'b1;
                                r_len_next   = depth_reg;
                                r_gw_next    = node_rdata.gw;
                                r_gwl_next   = node_rdata.gwlen;
                            end else if (best_hit_reg) begin
                                r_found_next = 1'b1;
                                r_len_next   = best_len_reg;
                                r_gw_next    = best_gw_reg;
                                r_gwl_next   = best_gwl_reg;
                            end else begin
                                r_status_next = brt_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (depth_reg == len_reg && node_rdata.is_end) begin
                                r_found_next = 1'b1;
                                r_len_next   = len_reg;
                                r_gw_next    = node_rdata.gw;
                                r_gwl_next   = node_rdata.gwlen;
                            end else begin
                                r_status_next = brt_pkg::ST_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            S_INS: begin
                if ({{(brt_pkg::CNT_W + 1 - brt_pkg::LEN_W){1'b0}}, missing} > avail) begin
                    r_status_next = brt_pkg::ST_FULL;
                    state_next    = S_DONE;
                end else if (depth_reg == len_reg) begin
                    state_next = S_IFIN;
                end else begin
                    state_next = S_IPOP;
                end
            end
            S_IPOP: begin
                if (cnt_reg != '0) begin
                    cnt_next      = cnt_reg - 1'b1;
                    from_stk_next = 1'b1;
                end else begin
                    new_idx_next  = alloc_reg[brt_pkg::NODE_W-1:0];
                    alloc_next    = alloc_reg + 1'b1;
                    from_stk_next = 1'b0;
                end
                state_next = S_ILINK;
            end
            S_ILINK: begin
                w = cur_data_reg;
                if (bit_cur) begin
                    w.child1 = idx;
                end else begin
                    w.child0 = idx;
                end
                node_we       = 1'b1;
                node_wdata    = w;
                cur_next      = idx;
                cur_data_next = '0;
                depth_next    = depth_reg + 1'b1;
                state_next    = (depth_reg + 1'b1 == len_reg) ? S_IFIN : S_IPOP;
            end
            S_IFIN: begin
                w        = cur_data_reg;
                w.is_end = 1'b1;
                w.gw     = gw_reg;
                w.gwlen  = gwl_reg;
                node_we    = 1'b1;
                node_wdata = w;
                state_next = S_DONE;
            end
            S_DCUT: begin
                w = anc_data_reg;
                if (brt_pkg::addr_bit(addr_reg, anc_d_reg)) begin
                    free_next = anc_data_reg.child1;
                    w.child1  = '0;
                end else begin
                    free_next = anc_data_reg.child0;
                    w.child0  = '0;
                end
                node_we    = 1'b1;
                node_waddr = anc_reg;
                node_wdata = w;
                depth_next = anc_d_reg + 1'b1;
                state_next = S_FREAD;
            end
            S_FREAD: begin
                node_raddr = free_reg;
                state_next = S_FPUSH;
            end
            S_FPUSH: begin
                if (cnt_reg < NODES_C) begin
                    stk_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (depth_reg < len_reg) begin
                    free_next  = nd_child;
                    node_raddr = nd_child;
                    depth_next = depth_reg + 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = r_status_reg;
                    m_found_next  = r_found_reg;
                    m_prefix_next = r_found_reg ?
                                    (addr_reg & brt_pkg::prefix_mask(r_len_reg)) : '0;
                    m_len_next    = r_len_reg;
                    m_gw_next     = r_gw_reg;
                    m_gwl_next    = r_gwl_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            alloc_reg   <= brt_pkg::CNT_W'(1);
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            alloc_reg   <= alloc_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        gw_reg       <= gw_next;
        gwl_reg      <= gwl_next;
        cur_reg      <= cur_next;
        depth_reg    <= depth_next;
        cur_data_reg <= cur_data_next;
        best_hit_reg <= best_hit_next;
        best_len_reg <= best_len_next;
        best_gw_reg  <= best_gw_next;
        best_gwl_reg <= best_gwl_next;
        anc_reg      <= anc_next;
        anc_d_reg    <= anc_d_next;
        anc_data_reg <= anc_data_next;
        new_idx_reg  <= new_idx_next;
        from_stk_reg <= from_stk_next;
        free_reg     <= free_next;
        r_status_reg <= r_status_next;
        r_found_reg  <= r_found_next;
        r_len_reg    <= r_len_next;
        r_gw_reg     <= r_gw_next;
        r_gwl_reg    <= r_gwl_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_prefix_reg <= m_prefix_next;
        m_len_reg    <= m_len_next;
        m_gw_reg     <= m_gw_next;
        m_gwl_reg    <= m_gwl_next;
    end

endmodule

[design/binary_trie_route_table_top.sv]
// Lookup, search and a delete that prunes nothing walk the trie along the address from request
// transfer, then load the result; insert also links each new node (or reports full), and a
// pruning delete also cuts the path and pushes each freed node on the recycle stack.
// Throughput: one request at a time; the next is taken in the cycle after the result is loaded.
// Reset: synchronous, active low; after reset the init state clears the root entry,
// then requests are taken. Node and recycle stack RAMs are not otherwise cleared.
// ----------------------------------------------------------------------------
// binary_trie_route_table_top: IPv4 longest-prefix-match route table
// Binary trie in a node RAM with a recycle stack RAM for freed nodes.
// ----------------------------------------------------------------------------
module binary_trie_route_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // prefix_addr, prefix_len, gateway, gateway_mask_len, pad
    input  logic [1:0]  s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata   // status, found, matched_prefix, matched_len,
                                  // matched_gateway, matched_gateway_mask_len, pad
);

    logic                          node_we;
    logic [brt_pkg::NODE_W-1:0]    node_waddr, node_raddr;
    brt_pkg::node_t                node_wdata, node_rdata;
    logic [brt_pkg::NODE_BITS-1:0] node_rbits;
    logic                          stk_we;
    logic [brt_pkg::NODE_W-1:0]    stk_waddr, stk_wdata, stk_raddr, stk_rdata;
    brt_pkg::brt_stat_t            stat;
    logic [1:0]                    m_status;
    logic                          m_found;
    logic [31:0]                   m_prefix, m_gw;
    logic [5:0]                    m_len, m_gwl;

    assign node_rdata = brt_pkg::node_t'(node_rbits);
    assign m_tdata    = {1'b0, m_gwl, m_gw, m_len, m_prefix, m_found, m_status};

    brt_ram #(.WIDTH(brt_pkg::NODE_BITS), .DEPTH(brt_pkg::NODES)) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rbits)
    );

    brt_ram #(.WIDTH(brt_pkg::NODE_W), .DEPTH(brt_pkg::NODES)) u_stk_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    brt_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_cmd      (s_tuser),
        .s_addr     (s_tdata[31:0]),
        .s_len      (s_tdata[37:32]),
        .s_gw       (s_tdata[69:38]),
        .s_gwl      (s_tdata[75:70]),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_status   (m_status),
        .m_found    (m_found),
        .m_prefix   (m_prefix),
        .m_len      (m_len),
        .m_gw       (m_gw),
        .m_gwl      (m_gwl),
        .node_we    (node_we),
        .node_waddr (node_waddr),
        .node_wdata (node_wdata),
        .node_raddr (node_raddr),
        .node_rdata (node_rdata),
        .stk_we     (stk_we),
        .stk_waddr  (stk_waddr),
        .stk_wdata  (stk_wdata),
        .stk_raddr  (stk_raddr),
        .stk_rdata  (stk_rdata),
        .stat       (stat)
    );

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.recycle_cnt <= brt_pkg::CNT_W'(brt_pkg::NODES))
        else $error("recycle count above pool size");

    a_alloc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.alloc_next != '0 && stat.alloc_next <= brt_pkg::CNT_W'(brt_pkg::NODES))
        else $error("allocation pointer out of range");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

endmodule
